[rtl/core/parr_pkg.sv]
// Shared types and constants for the phase-adaptive RRIP replacement block.
package parr_pkg;

    localparam int TAG_W   = 58;
    localparam int RRPV_W  = 2;
    localparam int REUSE_W = 3;
    localparam int CNT_W   = 8;
    localparam int ACC_W   = 7;
    localparam int ADDR_W  = 64;
    localparam int MASK_W  = 16;
    localparam int WIN_W   = 8;
    localparam int LINE_SH = 6;

    localparam logic [RRPV_W-1:0]  RRPV_MAX  = 2'd3;
    localparam logic [REUSE_W-1:0] REUSE_MAX = 3'd7;
    localparam logic [CNT_W-1:0]   CNT_MAX   = 8'd255;

    localparam logic CMD_VICTIM = 1'b0;
    localparam logic CMD_UPDATE = 1'b1;

    localparam logic [0:0] CFG_WINDOW = 1'd0;
    localparam logic [0:0] CFG_INSERT = 1'd1;

    // One way of a set row.
    typedef struct packed {
        logic               valid;
        logic [TAG_W-1:0]   tag;
        logic [RRPV_W-1:0]  rrpv;
        logic [REUSE_W-1:0] reuse;
    } t_way;

    // Per-set statistics.
    typedef struct packed {
        logic             phase;
        logic [CNT_W-1:0] shit;
        logic [CNT_W-1:0] imiss;
        logic [ACC_W-1:0] acc;
    } t_set_stat;

    // Controller to datapath commands.
    typedef struct packed {
        logic rd;     // issue row read
        logic load;   // capture read row
        logic scan;   // one scan or aging step
        logic wr;     // write row back
        logic done;   // capture result
    } t_ctl_cmd;

    // Datapath to controller status.
    typedef struct packed {
        logic found;  // search finished
    } t_ctl_sts;

endpackage

[rtl/core/parr_ctrl.sv]
// Controller state machine: sequences read, scan, writeback and result.
module parr_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_out_free,
    input  parr_pkg::t_ctl_sts i_sts,
    output parr_pkg::t_ctl_cmd o_cmd,
    output logic              o_idle
);
    import parr_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_READ = 5'b00010,
        S_LOAD = 5'b00100,
        S_SCAN = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_idle  = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_idle = 1'b1;
                if (i_start) begin
                    o_cmd.rd = 1'b1;
                    n_state  = S_READ;
                end
            end
            S_READ: begin
                n_state = S_LOAD;
            end
            S_LOAD: begin
                o_cmd.load = 1'b1;
                n_state    = S_SCAN;
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.found) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_out_free) begin
                    o_cmd.wr   = 1'b1;
                    o_cmd.done = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

[rtl/core/parr_dp.sv]
// Datapath: set row memories, clearing sweep, victim scan and update logic.
module parr_dp #(
    parameter int NUM_SETS = 2048,
    parameter int NUM_WAYS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic                        i_cmd,
    input  logic [10:0]                 i_set_index,
    input  logic [3:0]                  i_way_index,
    input  logic                        i_hit_flag,
    input  logic [parr_pkg::ADDR_W-1:0] i_address,
    input  logic [parr_pkg::MASK_W-1:0] i_cache_valid_mask,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_idx,
    input  logic [7:0]                  i_cfg_data,
    input  parr_pkg::t_ctl_cmd          i_cmd_bus,
    output parr_pkg::t_ctl_sts          o_sts,
    output logic                        o_clearing,
    output logic [3:0]                  o_victim_way,
    output logic                        o_bypassed,
    output logic                        o_phase
);
    import parr_pkg::*;

    localparam int SET_W = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
    localparam int WAY_W = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;

    typedef t_way [NUM_WAYS-1:0] t_row;

    t_row      mem_row  [NUM_SETS];
    t_set_stat mem_stat [NUM_SETS];

    logic [WIN_W-1:0]  r_window;
    logic [RRPV_W-1:0] r_insert;
    logic [SET_W:0]    r_clr;
    logic              r_clearing;

    logic [SET_W-1:0]  r_set;
    logic              r_op;
    logic [WAY_W-1:0]  r_way;
    logic              r_hit;
    logic [TAG_W-1:0]  r_tag;
    logic [MASK_W-1:0] r_mask;
    t_row              r_rd_row, r_row;
    t_set_stat         r_rd_stat, r_stat;
    logic              r_protect;
    logic              r_found;
    logic [WAY_W-1:0]  r_victim;
    logic              r_byp;
    logic [NUM_WAYS-1:0] r_nb;      // per-way protection bits

    logic [SET_W-1:0] set_red;
    logic [WAY_W-1:0] way_red;

    always_comb begin
        set_red = SET_W'(32'(i_set_index) % NUM_SETS);
        way_red = WAY_W'(32'(i_way_index) % NUM_WAYS);
    end

    function automatic logic near(input t_way w, input logic [TAG_W-1:0] t,
                                  input logic [WIN_W-1:0] win);
        logic [TAG_W-1:0] d;
        d = (w.tag >= t) ? (w.tag - t) : (t - w.tag);
        return w.valid && (d <= TAG_W'(win));
    endfunction

    // Clearing sweep and configuration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window   <= 8'd2;
            r_insert   <= 2'd2;
            r_clr      <= '0;
            r_clearing <= 1'b1;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_WINDOW) begin
                    r_window <= i_cfg_data;
                end else begin
                    r_insert <= i_cfg_data[RRPV_W-1:0];
                end
            end
            if (r_clearing) begin
                if (r_clr == (SET_W+1)'(NUM_SETS - 1)) begin
                    r_clearing <= 1'b0;
                end
                r_clr <= r_clr + 1'b1;
            end
        end
    end

    t_row      clr_row;
    t_set_stat clr_stat;
    always_comb begin
        for (int w = 0; w < NUM_WAYS; w++) begin
            clr_row[w] = '{valid: 1'b0, tag: '0, rrpv: RRPV_MAX, reuse: '0};
        end
        clr_stat = '{phase: 1'b1, shit: '0, imiss: '0, acc: '0};
    end

    // Update result row and statistics.
    t_row      upd_row;
    t_set_stat upd_stat;
    logic      upd_nb;
    logic      upd_byp;
    always_comb begin
        upd_nb = 1'b0;
        for (int w = 0; w < NUM_WAYS; w++) begin
            if (WAY_W'(w) != r_way && near(r_row[w], r_tag, r_window)) begin
                upd_nb = 1'b1;
            end
        end
        upd_row  = r_row;
        upd_stat = r_stat;
        upd_byp  = 1'b0;
        upd_stat.acc = r_stat.acc + 1'b1;
        if (r_hit) begin
            upd_row[r_way].rrpv = '0;
            if (r_row[r_way].reuse != REUSE_MAX) begin
                upd_row[r_way].reuse = r_row[r_way].reuse + 1'b1;
            end
            if (upd_nb && r_stat.shit != CNT_MAX) begin
                upd_stat.shit = r_stat.shit + 1'b1;
            end
        end else if (!r_stat.phase && !upd_nb) begin
            upd_row[r_way] = '{valid: 1'b0, tag: '0, rrpv: RRPV_MAX, reuse: '0};
            if (r_stat.imiss != CNT_MAX) begin
                upd_stat.imiss = r_stat.imiss + 1'b1;
            end
            upd_byp = 1'b1;
        end else begin
            upd_row[r_way] = '{valid: 1'b1, tag: r_tag,
                               rrpv: upd_nb ? r_insert : RRPV_MAX, reuse: 3'd1};
            if (!upd_nb && r_stat.imiss != CNT_MAX) begin
                upd_stat.imiss = r_stat.imiss + 1'b1;
            end
        end
        if (upd_stat.acc == '0) begin
            upd_stat.phase = upd_stat.shit > upd_stat.imiss;
            upd_stat.shit  = upd_stat.shit >> 1;
            upd_stat.imiss = upd_stat.imiss >> 1;
        end
    end

    // One victim search pass over the captured row.
    logic             srch_hit;
    logic [WAY_W-1:0] srch_way;
    logic [3:0]       srch_best;
    logic             inv_hit;
    logic [WAY_W-1:0] inv_way;
    always_comb begin
        srch_hit  = 1'b0;
        srch_way  = '0;
        srch_best = 4'd8;
        for (int w = 0; w < NUM_WAYS; w++) begin
            if (r_row[w].rrpv == RRPV_MAX && !(r_protect && r_nb[w])
                && {1'b0, r_row[w].reuse} < srch_best) begin
                srch_best = {1'b0, r_row[w].reuse};
                srch_way  = WAY_W'(w);
                srch_hit  = 1'b1;
            end
        end
        inv_hit = 1'b0;
        inv_way = '0;
        for (int w = NUM_WAYS - 1; w >= 0; w--) begin
            if (w < MASK_W && !r_mask[w]) begin
                inv_hit = 1'b1;
                inv_way = WAY_W'(w);
            end
        end
    end

    // Per-way protection: neighbour among the other ways.
    logic [NUM_WAYS-1:0] nb_vec;
    always_comb begin
        for (int v = 0; v < NUM_WAYS; v++) begin
            nb_vec[v] = 1'b0;
            for (int w = 0; w < NUM_WAYS; w++) begin
                if (w != v && near(r_rd_row[w], r_rd_row[v].tag, r_window)) begin
                    nb_vec[v] = 1'b1;
                end
            end
        end
    end

    // Memory ports.
    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            mem_row[r_clr[SET_W-1:0]]  <= clr_row;
            mem_stat[r_clr[SET_W-1:0]] <= clr_stat;
        end else if (i_cmd_bus.wr) begin
            mem_row[r_set]  <= r_row;
            mem_stat[r_set] <= r_stat;
        end
        if (i_cmd_bus.rd) begin
            r_rd_row  <= mem_row[set_red];
            r_rd_stat <= mem_stat[set_red];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_set  <= set_red;
            r_op   <= i_cmd;
            r_way  <= way_red;
            r_hit  <= i_hit_flag;
            r_tag  <= i_address[LINE_SH +: TAG_W];
            r_mask <= i_cache_valid_mask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (i_cmd_bus.load) begin
            r_found   <= 1'b0;
            r_row     <= r_rd_row;
            r_stat    <= r_rd_stat;
            r_protect <= r_rd_stat.phase;
            r_nb      <= nb_vec;
        end else if (i_cmd_bus.scan && !r_found) begin
            if (r_op == CMD_UPDATE) begin
                r_found  <= 1'b1;
                r_row    <= upd_row;
                r_stat   <= upd_stat;
                r_byp    <= upd_byp;
                r_victim <= '0;
            end else if (inv_hit) begin
                r_found  <= 1'b1;
                r_byp    <= 1'b0;
                r_victim <= inv_way;
            end else if (srch_hit) begin
                r_found  <= 1'b1;
                r_byp    <= 1'b0;
                r_victim <= srch_way;
            end else begin
                r_protect <= 1'b0;
                for (int w = 0; w < NUM_WAYS; w++) begin
                    if (r_row[w].rrpv != RRPV_MAX) begin
                        r_row[w].rrpv <= r_row[w].rrpv + 1'b1;
                    end
                end
            end
        end
    end

    assign o_sts.found = r_found;
    assign o_clearing  = r_clearing;
    assign o_victim_way = 4'(r_victim);
    assign o_bypassed   = r_byp;
    assign o_phase      = r_stat.phase;

endmodule

[rtl/core/phase_adaptive_rrip_replacement.sv]
// Top level of the phase-adaptive RRIP replacement block.
//  channel   dir  handshake           contents
//  s_axis    in   tvalid/tready       request: set, way, hit, address, mask, cmd
//  m_axis    out  tvalid/tready       result: victim way, bypassed, phase
//  cfg       in   i_cfg_we            register index and write data
// A request holds the block from its accepting edge through read, capture, scan and
// writeback; a victim search also ages the RRPVs in the scan state, at most three
// aging steps, until it finds a victim. The controller's state sequence sets this.
// After reset a clearing pass over all NUM_SETS sets runs before the first request.
// The result sits in an output register; a new request may be taken while it waits,
// and that request holds in writeback until the register is free.
module phase_adaptive_rrip_replacement #(
    parameter int NUM_SETS = 2048,
    parameter int NUM_WAYS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [95:0]   s_axis_tdata,  // set_index, way_index, hit_flag, address, mask
    input  logic          s_axis_tuser,  // cmd
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [7:0]    m_axis_tdata,  // victim_way, bypassed, phase
    input  logic          i_cfg_we,
    input  logic          i_cfg_idx,
    input  logic [7:0]    i_cfg_data
);
    import parr_pkg::*;

    t_ctl_cmd cmd_bus;
    t_ctl_sts sts;
    logic     idle, clearing, start, r_ovalid;
    logic [3:0] victim;
    logic       byp, phase;
    logic [5:0] r_odata;

    assign s_axis_tready = idle && !clearing;
    assign start = s_axis_tvalid && s_axis_tready;

    parr_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start),
        .i_out_free(!r_ovalid), .i_sts(sts), .o_cmd(cmd_bus), .o_idle(idle)
    );

    parr_dp #(.NUM_SETS(NUM_SETS), .NUM_WAYS(NUM_WAYS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start),
        .i_cmd(s_axis_tuser),
        .i_set_index(s_axis_tdata[10:0]), .i_way_index(s_axis_tdata[14:11]),
        .i_hit_flag(s_axis_tdata[15]), .i_address(s_axis_tdata[79:16]),
        .i_cache_valid_mask(s_axis_tdata[95:80]),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_cmd_bus(cmd_bus), .o_sts(sts), .o_clearing(clearing),
        .o_victim_way(victim), .o_bypassed(byp), .o_phase(phase)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (cmd_bus.done) begin
            r_ovalid <= 1'b1;
        end else if (m_axis_tready) begin
            r_ovalid <= 1'b0;
        end
        if (cmd_bus.done) begin
            r_odata <= {phase, byp, victim};
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {2'b00, r_odata};

endmodule

[rtl/core/parr_checker.sv]
// Port-level checker for the replacement block, bound to the top level.
module parr_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       s_axis_tvalid,
    input logic       s_axis_tready,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata
);
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request taken while busy");
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[7:6] == 2'b00) else $error("padding not zero");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped");
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && !m_axis_tvalid
        |=> !m_axis_tvalid ##1 !m_axis_tvalid)
        else $error("result too early");
endmodule

bind phase_adaptive_rrip_replacement parr_checker u_parr_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
);
